FILE: hw/rtl/c1r_pkg.sv
`timescale 1ns / 1ps

package c1r_pkg;

    // Field widths of the channels.
    localparam int OP_W        = 2;
    localparam int INDEX_W     = 11;
    localparam int VALUE_W     = 16;
    localparam int OUT_CHAN_W  = 4;
    localparam int OUT_VALUE_W = 15;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 5;

    // Largest layer shape. The channel field widths above are sized for it.
    localparam int MAX_IN_CHANNELS  = 16;
    localparam int MAX_OUT_CHANNELS = 16;
    localparam int MAX_KERNEL       = 8;

    // Q8.8 fraction bits and the saturation limit of a result.
    localparam int                     FRAC_W  = 8;
    localparam logic [OUT_VALUE_W-1:0] SAT_MAX = 15'h7FFF;

    typedef logic [OP_W-1:0]           t_op;
    typedef logic [INDEX_W-1:0]        t_index;
    typedef logic signed [VALUE_W-1:0] t_value;
    typedef logic [CFG_INDEX_W-1:0]    t_cfg_index;
    typedef logic [CFG_DATA_W-1:0]     t_cfg_data;

    // Operation codes of an input transaction.
    localparam t_op OP_WEIGHT  = 2'd0;
    localparam t_op OP_BIAS    = 2'd1;
    localparam t_op OP_SAMPLE  = 2'd2;
    localparam t_op OP_RESTART = 2'd3;

    // Configuration register indexes.
    localparam t_cfg_index REG_IN_CHANNELS  = 2'd0;
    localparam t_cfg_index REG_OUT_CHANNELS = 2'd1;
    localparam t_cfg_index REG_WINDOW_LEN   = 2'd2;

    // Control that travels with one multiply-accumulate term.
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } t_mac_ctl;

endpackage

FILE: hw/rtl/c1r_ifs.sv
`timescale 1ns / 1ps

interface c1r_in_if
    import c1r_pkg::*;
();
    logic   valid;
    logic   ready;
    t_op    op;
    t_index index;
    t_value value;

    modport source (output valid, output op, output index, output value, input ready);
    modport sink   (input valid, input op, input index, input value, output ready);
endinterface

interface c1r_out_if
    import c1r_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [OUT_CHAN_W-1:0]  out_channel;
    logic [OUT_VALUE_W-1:0] out_value;
    logic                   last;

    modport source (output valid, output out_channel, output out_value, output last,
                    input ready);
    modport sink   (input valid, input out_channel, input out_value, input last,
                    output ready);
endinterface

interface c1r_cfg_if
    import c1r_pkg::*;
();
    logic       valid;
    logic       ready;
    t_cfg_index index;
    t_cfg_data  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/c1r_mac.sv
`timescale 1ns / 1ps

module c1r_mac
    import c1r_pkg::*;
#(
    parameter int TERMS = 128
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_mac_ctl               i_ctl,
    input  t_value                 i_weight,
    input  t_value                 i_sample,
    input  t_value                 i_bias,
    output logic                   o_done,
    output logic [OUT_VALUE_W-1:0] o_result
);

    // Products are Q16.16 and at most TERMS of them are summed, plus the bias.
    localparam int ACC_W = 2 * VALUE_W + $clog2(TERMS + 1) + 1;

    t_mac_ctl                  r_ctl;
    logic signed [2*VALUE_W-1:0] r_prod;
    logic signed [ACC_W-1:0]   r_acc;
    logic                      r_done;
    logic signed [ACC_W-1:0]   n_acc;
    logic signed [ACC_W-1:0]   acc_base;
    logic signed [ACC_W-1:0]   acc_shift;

    always_comb begin
        acc_base = r_ctl.first ? (ACC_W'(i_bias) <<< FRAC_W) : r_acc;
        n_acc    = acc_base + ACC_W'(r_prod);
    end

    always_ff @(posedge i_clk) begin
        r_prod <= i_weight * i_sample;
        if (r_ctl.valid) begin
            r_acc <= n_acc;
        end
        if (!i_rst_n) begin
            r_ctl  <= '0;
            r_done <= 1'b0;
        end else begin
            r_ctl  <= i_ctl;
            r_done <= r_ctl.valid && r_ctl.last;
        end
    end

    // ReLU, truncation to unsigned Q7.8 and saturation.
    always_comb begin
        acc_shift = r_acc >>> FRAC_W;
        if (r_acc <= 0) begin
            o_result = '0;
        end else if (acc_shift > ACC_W'(SAT_MAX)) begin
            o_result = SAT_MAX;
        end else begin
            o_result = acc_shift[OUT_VALUE_W-1:0];
        end
    end

    assign o_done = r_done;

endmodule

FILE: hw/rtl/conv1d_relu_stream.sv
`timescale 1ns / 1ps

// Channel     Dir  Payload                               Transaction
// i_sample    in   op, index, value                      valid && ready
// o_result    out  out_channel, out_value, last          valid && ready
// i_cfg       in   index, data                           valid && ready
//
// Weight, bias and restart transactions and samples that do not complete a full
// window leave the sequencer idle. A sample that completes a full window holds
// input ready low while the filter loop runs all O filters: C * K terms per
// filter on the one multiplier, the read, multiply and accumulate registers,
// and the hand-over. Reset is synchronous and active low; no clearing pass.
// A full output register stalls the filter loop at a hand-over, and so the input.
module conv1d_relu_stream
    import c1r_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    c1r_in_if.sink     i_sample,
    c1r_out_if.source  o_result,
    c1r_cfg_if.sink    i_cfg
);

    // Store geometry. The weight store is laid out so that one frame's filter
    // loop reads it strictly in address order.
    localparam int WT_DEPTH  = MAX_IN_CHANNELS * MAX_KERNEL * MAX_OUT_CHANNELS;
    localparam int WIN_DEPTH = MAX_IN_CHANNELS * MAX_KERNEL;
    localparam int WT_AW     = (WT_DEPTH > 1) ? $clog2(WT_DEPTH) : 1;
    localparam int WIN_AW    = (WIN_DEPTH > 1) ? $clog2(WIN_DEPTH) : 1;
    localparam int BIAS_AW   = (MAX_OUT_CHANNELS > 1) ? $clog2(MAX_OUT_CHANNELS) : 1;

    // Counter widths hold the largest count itself.
    localparam int IC_W = $clog2(MAX_IN_CHANNELS + 1);
    localparam int OC_W = $clog2(MAX_OUT_CHANNELS + 1);
    localparam int K_W  = $clog2(MAX_KERNEL + 1);

    // Sequencer states.
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    // Stores: synchronous memories with registered reads.
    t_value weight_mem [WT_DEPTH];
    t_value window_mem [WIN_DEPTH];
    t_value bias_mem   [MAX_OUT_CHANNELS];

    // Configuration, kept already clamped into the legal range.
    logic [IC_W-1:0] r_c;
    logic [OC_W-1:0] r_o;
    logic [K_W-1:0]  r_kl;

    // Window fill state.
    logic [IC_W-1:0] r_chpos;
    logic [K_W-1:0]  r_filled;
    logic [K_W-1:0]  r_head;

    // Filter loop state.
    logic [1:0]       r_state;
    logic [OC_W-1:0]  r_k;
    logic [IC_W-1:0]  r_q;
    logic [K_W-1:0]   r_dn;
    logic [K_W-1:0]   r_slot;
    logic [WT_AW-1:0] r_wa;

    // Read data and the control that lines up with it.
    t_value   r_wt_rd;
    t_value   r_win_rd;
    t_value   r_bias_rd;
    t_mac_ctl r_s1_ctl;

    // Output register.
    logic                   r_out_valid;
    logic [OUT_CHAN_W-1:0]  r_out_chan;
    logic [OUT_VALUE_W-1:0] r_out_value;
    logic                   r_out_last;

    logic                   cfg_fire;
    logic                   in_fire;
    logic [31:0]            cfg_val;
    logic [31:0]            cfg_len_val;
    logic [31:0]            idx_wide;
    logic [31:0]            k_wide;
    logic                   wt_we;
    logic                   bias_we;
    logic                   win_we;

    logic [IC_W-1:0]        pos;
    logic [K_W-1:0]         head;
    logic [IC_W-1:0]        pos_inc;
    logic [K_W-1:0]         head_inc;
    logic [K_W-1:0]         head_next;
    logic [K_W-1:0]         filled_next;
    logic                   frame_done;
    logic                   window_full;
    logic [WIN_AW-1:0]      win_wr_addr;
    logic [WIN_AW-1:0]      win_rd_addr;

    logic                   issue;
    logic                   q_end;
    logic                   dn_end;
    t_mac_ctl               issue_ctl;
    logic [K_W-1:0]         slot_inc;
    logic                   out_free;
    logic                   k_end;
    logic                   mac_done;
    logic [OUT_VALUE_W-1:0] mac_result;

    assign i_cfg.ready    = (r_state == ST_IDLE);
    assign i_sample.ready = (r_state == ST_IDLE) && !i_cfg.valid;
    assign cfg_fire       = i_cfg.valid && i_cfg.ready;
    assign in_fire        = i_sample.valid && i_sample.ready;

    assign cfg_val     = 32'(i_cfg.data);
    assign cfg_len_val = 32'(i_cfg.data[3:0]);
    assign idx_wide    = 32'(i_sample.index);
    assign k_wide      = 32'(r_k);

    // Writes beyond a store are dropped.
    assign wt_we   = in_fire && (i_sample.op == OP_WEIGHT) && (idx_wide < 32'(WT_DEPTH));
    assign bias_we = in_fire && (i_sample.op == OP_BIAS)
                     && (idx_wide < 32'(MAX_OUT_CHANNELS));
    assign win_we  = in_fire && (i_sample.op == OP_SAMPLE);

    // Sample bookkeeping. Positions out of range restart at zero.
    always_comb begin
        pos         = (r_chpos >= r_c) ? '0 : r_chpos;
        head        = (r_head >= r_kl) ? '0 : r_head;
        pos_inc     = pos + IC_W'(1);
        frame_done  = (pos_inc == r_c);
        head_inc    = head + K_W'(1);
        head_next   = (head_inc >= r_kl) ? '0 : head_inc;
        filled_next = (r_filled < r_kl) ? (r_filled + K_W'(1)) : r_filled;
        window_full = (filled_next >= r_kl);
        win_wr_addr = WIN_AW'(32'(head) * 32'(MAX_IN_CHANNELS) + 32'(pos));
    end

    // Filter loop: the channel index runs fastest, then the window slot from
    // oldest to newest. The weight address simply counts up across the frame.
    always_comb begin
        issue           = (r_state == ST_RUN);
        q_end           = ((r_q + IC_W'(1)) == r_c);
        dn_end          = ((r_dn + K_W'(1)) == r_kl);
        issue_ctl.valid = issue;
        issue_ctl.first = (r_q == '0) && (r_dn == '0);
        issue_ctl.last  = q_end && dn_end;
        slot_inc        = r_slot + K_W'(1);
        win_rd_addr     = WIN_AW'(32'(r_slot) * 32'(MAX_IN_CHANNELS) + 32'(r_q));
        out_free        = !r_out_valid || o_result.ready;
        k_end           = ((r_k + OC_W'(1)) == r_o);
    end

    always_ff @(posedge i_clk) begin
        if (wt_we) begin
            weight_mem[idx_wide[WT_AW-1:0]] <= i_sample.value;
        end
        r_wt_rd <= weight_mem[r_wa];
    end

    always_ff @(posedge i_clk) begin
        if (win_we) begin
            window_mem[win_wr_addr] <= i_sample.value;
        end
        r_win_rd <= window_mem[win_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (bias_we) begin
            bias_mem[idx_wide[BIAS_AW-1:0]] <= i_sample.value;
        end
        r_bias_rd <= bias_mem[r_k[BIAS_AW-1:0]];
    end

    c1r_mac #(
        .TERMS (WIN_DEPTH)
    ) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (r_s1_ctl),
        .i_weight (r_wt_rd),
        .i_sample (r_win_rd),
        .i_bias   (r_bias_rd),
        .o_done   (mac_done),
        .o_result (mac_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_c         <= IC_W'(1);
            r_o         <= OC_W'(1);
            r_kl        <= K_W'(1);
            r_chpos     <= '0;
            r_filled    <= '0;
            r_head      <= '0;
            r_k         <= '0;
            r_q         <= '0;
            r_dn        <= '0;
            r_slot      <= '0;
            r_wa        <= '0;
            r_s1_ctl    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_ctl <= issue_ctl;

            // In the hand-over state the output register is loaded below instead.
            if (r_out_valid && o_result.ready && (r_state != ST_EMIT)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (cfg_fire) begin
                        // A write to any of the three registers restarts the window fill.
                        case (i_cfg.index)
                            REG_IN_CHANNELS: begin
                                r_c <= (cfg_val == 32'd0) ? IC_W'(1) :
                                       (cfg_val > 32'(MAX_IN_CHANNELS)) ?
                                       IC_W'(MAX_IN_CHANNELS) : IC_W'(cfg_val);
                                r_chpos  <= '0;
                                r_filled <= '0;
                                r_head   <= '0;
                            end
                            REG_OUT_CHANNELS: begin
                                r_o <= (cfg_val == 32'd0) ? OC_W'(1) :
                                       (cfg_val > 32'(MAX_OUT_CHANNELS)) ?
                                       OC_W'(MAX_OUT_CHANNELS) : OC_W'(cfg_val);
                                r_chpos  <= '0;
                                r_filled <= '0;
                                r_head   <= '0;
                            end
                            REG_WINDOW_LEN: begin
                                r_kl <= (cfg_len_val == 32'd0) ? K_W'(1) :
                                        (cfg_len_val > 32'(MAX_KERNEL)) ?
                                        K_W'(MAX_KERNEL) : K_W'(cfg_len_val);
                                r_chpos  <= '0;
                                r_filled <= '0;
                                r_head   <= '0;
                            end
                            default: begin
                            end
                        endcase
                    end else if (in_fire) begin
                        case (i_sample.op)
                            OP_RESTART: begin
                                r_chpos  <= '0;
                                r_filled <= '0;
                                r_head   <= '0;
                            end
                            OP_SAMPLE: begin
                                if (!frame_done) begin
                                    r_chpos <= pos_inc;
                                end else begin
                                    r_chpos  <= '0;
                                    r_head   <= head_next;
                                    r_filled <= filled_next;
                                    if (window_full) begin
                                        // The oldest frame now sits at the ring head.
                                        r_k     <= '0;
                                        r_q     <= '0;
                                        r_dn    <= '0;
                                        r_slot  <= head_next;
                                        r_wa    <= '0;
                                        r_state <= ST_RUN;
                                    end
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end

                ST_RUN: begin
                    r_wa <= r_wa + WT_AW'(1);
                    if (q_end) begin
                        r_q    <= '0;
                        r_dn   <= r_dn + K_W'(1);
                        r_slot <= (slot_inc >= r_kl) ? '0 : slot_inc;
                        if (dn_end) begin
                            r_state <= ST_DRAIN;
                        end
                    end else begin
                        r_q <= r_q + IC_W'(1);
                    end
                end

                ST_DRAIN: begin
                    // Wait until the last term of this filter is accumulated.
                    if (mac_done) begin
                        r_state <= ST_EMIT;
                    end
                end

                ST_EMIT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_chan  <= k_wide[OUT_CHAN_W-1:0];
                        r_out_value <= mac_result;
                        r_out_last  <= k_end;
                        if (k_end) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_k     <= r_k + OC_W'(1);
                            r_q     <= '0;
                            r_dn    <= '0;
                            r_slot  <= r_head;
                            r_state <= ST_RUN;
                        end
                    end
                end

                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.out_channel = r_out_chan;
    assign o_result.out_value   = r_out_value;
    assign o_result.last        = r_out_last;

endmodule

FILE: tb/tb_conv1d_relu_stream.sv
`timescale 1ns / 1ps

module tb_conv1d_relu_stream;
    import c1r_pkg::*;

    // Clock period and the number of cycles without any transaction on any
    // channel after which the run is declared hung. The slowest legal stretch
    // is the long output hold plus one full filter pass plus a sender gap,
    // so the limit leaves a wide margin.
    localparam int CLK_PERIOD     = 8;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int WEIGHT_DEPTH   = 2048;
    localparam int BIAS_DEPTH     = 16;
    localparam int WINDOW_DEPTH   = 128;
    // No layer shape below reads a weight at or above this address.
    localparam int WEIGHT_PRELOAD = 128;

    // The configuration index that names no register. A write to it must be
    // ignored and must leave the window fill alone.
    localparam t_cfg_index REG_SPARE = 2'd3;

    // One result of one filter, as the output channel carries it.
    typedef struct {
        logic [OUT_CHAN_W-1:0]  chan;
        logic [OUT_VALUE_W-1:0] value;
        logic                   last;
    } t_filter_output;

    // Ready patterns of the result receiver. Each pattern holds for a random
    // number of cycles before a new one is drawn.
    typedef enum int {
        ALWAYS_READY,
        HALF_READY,
        RARE_READY,
        MOSTLY_READY
    } t_stall_mode;

    // The checker keeps its own copy of the registers and the stores, works
    // out the results of each accepted input transaction, and compares every
    // accepted result with the oldest one still waiting.
    class conv_layer_checker;
        t_cfg_data      in_reg;
        t_cfg_data      out_reg;
        logic [3:0]     win_reg;
        t_value         weights [WEIGHT_DEPTH];
        t_value         biases [BIAS_DEPTH];
        t_value         window [WINDOW_DEPTH];
        int unsigned    chan_pos;
        int unsigned    frames_filled;
        int unsigned    ring_head;
        t_filter_output pending_outputs [$];
        int unsigned    errors;
        int unsigned    outputs_checked;
        int unsigned    items_taken;

        function new();
            in_reg          = 1;
            out_reg         = 1;
            win_reg         = 1;
            errors          = 0;
            outputs_checked = 0;
            items_taken     = 0;
            clear_fill();
        endfunction

        function void clear_fill();
            chan_pos      = 0;
            frames_filled = 0;
            ring_head     = 0;
        endfunction

        // Register values outside the legal range act as the nearest bound.
        static function int unsigned clamp_count(int unsigned v, int unsigned hi);
            if (v < 1)
                return 1;
            if (v > hi)
                return hi;
            return v;
        endfunction

        function int unsigned eff_in();
            return clamp_count(in_reg, 16);
        endfunction

        function int unsigned eff_out();
            return clamp_count(out_reg, 16);
        endfunction

        function int unsigned eff_win();
            return clamp_count(win_reg, 8);
        endfunction

        // Cycles the block may spend on one completed frame.
        function int unsigned busy_cycles();
            return eff_out() * (eff_in() * eff_win() + 4) + 1;
        endfunction

        function int unsigned pending_count();
            return pending_outputs.size();
        endfunction

        function void write_register(t_cfg_index idx, t_cfg_data data);
            case (idx)
                REG_IN_CHANNELS:  in_reg = data;
                REG_OUT_CHANNELS: out_reg = data;
                REG_WINDOW_LEN:   win_reg = data[3:0];
                default:          return;
            endcase
            clear_fill();
        endfunction

        // Stores one sample and, when it completes a frame of a full window,
        // queues one ReLU result per filter.
        function void compute_filter_outputs(t_value val);
            int unsigned    c;
            int unsigned    o;
            int unsigned    kl;
            int unsigned    slot;
            int unsigned    wa;
            int             prod;
            longint         acc;
            t_filter_output r;
            c  = eff_in();
            o  = eff_out();
            kl = eff_win();
            if (chan_pos >= c)
                chan_pos = 0;
            if (ring_head >= kl)
                ring_head = 0;
            window[ring_head * 16 + chan_pos] = val;
            chan_pos++;
            if (chan_pos < c)
                return;
            chan_pos = 0;
            ring_head++;
            if (ring_head >= kl)
                ring_head = 0;
            if (frames_filled < kl)
                frames_filled++;
            if (frames_filled < kl)
                return;
            for (int unsigned k = 0; k < o; k++) begin
                acc = biases[k];
                acc = acc * 256;
                // The ring head now points at the oldest frame.
                for (int unsigned dn = 0; dn < kl; dn++) begin
                    slot = ring_head + dn;
                    if (slot >= kl)
                        slot -= kl;
                    for (int unsigned q = 0; q < c; q++) begin
                        wa   = q + c * (dn + kl * k);
                        prod = weights[wa] * window[slot * 16 + q];
                        acc += prod;
                    end
                end
                r.chan = k[OUT_CHAN_W-1:0];
                r.last = (k + 1 == o);
                if (acc <= 0) begin
                    r.value = '0;
                end else begin
                    acc = acc >>> FRAC_W;
                    r.value = (acc > longint'(SAT_MAX)) ? SAT_MAX : acc[OUT_VALUE_W-1:0];
                end
                pending_outputs.push_back(r);
            end
        endfunction

        function void take_item(t_op op, t_index idx, t_value val);
            items_taken++;
            case (op)
                OP_WEIGHT:  weights[idx] = val;
                OP_BIAS: begin
                    if (idx < BIAS_DEPTH)
                        biases[idx] = val;
                end
                OP_RESTART: clear_fill();
                default:    compute_filter_outputs(val);
            endcase
        endfunction

        function void check_output(logic [OUT_CHAN_W-1:0] chan,
                                   logic [OUT_VALUE_W-1:0] value, logic last);
            t_filter_output exp;
            outputs_checked++;
            if (pending_outputs.size() == 0) begin
                errors++;
                $display("%0t: result with nothing expected: channel %0d value %0d last %0b",
                         $time, chan, value, last);
                return;
            end
            exp = pending_outputs.pop_front();
            if (chan !== exp.chan) begin
                errors++;
                $display("%0t: out_channel mismatch: expected %0d, actual %0d",
                         $time, exp.chan, chan);
            end
            if (value !== exp.value) begin
                errors++;
                $display("%0t: out_value mismatch on channel %0d: expected %0d, actual %0d",
                         $time, exp.chan, exp.value, value);
            end
            if (last !== exp.last) begin
                errors++;
                $display("%0t: last mismatch on channel %0d: expected %0b, actual %0b",
                         $time, exp.chan, exp.last, last);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    c1r_in_if  sample_if ();
    c1r_out_if result_if ();
    c1r_cfg_if cfg_if ();

    conv1d_relu_stream dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (sample_if),
        .o_result (result_if),
        .i_cfg    (cfg_if)
    );

    conv_layer_checker layer_chk;

    // Sender burst state, shared by the driving tasks.
    int unsigned burst_left;
    bit          sender_gaps;
    // Set by the main sequence to ask the receiver for a long hold-off.
    int unsigned hold_request;
    int unsigned phases_run;
    int unsigned stalled_cycles;

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // All three channels are observed at the rising edge. Results are checked
    // before the input transaction of the same edge is taken, although a
    // result can never stem from an input accepted at that very edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cfg_if.valid && cfg_if.ready)
                layer_chk.write_register(cfg_if.index, cfg_if.data);
            if (result_if.valid && result_if.ready)
                layer_chk.check_output(result_if.out_channel, result_if.out_value,
                                       result_if.last);
            if (sample_if.valid && sample_if.ready)
                layer_chk.take_item(sample_if.op, sample_if.index, sample_if.value);
        end
    end

    // The watchdog ends a run in which no channel has moved a transaction for
    // too long.
    always @(posedge i_clk) begin
        if (stalled_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, stalled_cycles);
            $display("Test completed with failures");
            $finish;
        end else if ((cfg_if.valid && cfg_if.ready) || (result_if.valid && result_if.ready)
                     || (sample_if.valid && sample_if.ready)) begin
            stalled_cycles <= 0;
        end else begin
            stalled_cycles <= stalled_cycles + 1;
        end
    end

    // The result receiver. It draws a ready pattern for a random stretch of
    // cycles, and it honors a request for a long hold-off by counting the
    // cycles itself, so the block fills up and pushes back on its input.
    initial begin
        t_stall_mode mode;
        int unsigned mode_left;
        int unsigned hold_left;
        mode      = ALWAYS_READY;
        mode_left = 0;
        hold_left = 0;
        result_if.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_request != 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0) begin
                hold_left--;
                result_if.ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = t_stall_mode'($urandom_range(0, 3));
                    mode_left = $urandom_range(4, 60);
                end
                mode_left--;
                case (mode)
                    ALWAYS_READY: result_if.ready <= 1'b1;
                    HALF_READY:   result_if.ready <= ($urandom_range(0, 1) == 1);
                    RARE_READY:   result_if.ready <= ($urandom_range(0, 3) == 0);
                    default:      result_if.ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // Random Q8.8 values. Most are small so that sums land in the useful
    // range, and some are full scale or exactly at the extremes so that
    // saturation and clipping to zero both occur.
    function automatic t_value pick_value();
        case ($urandom_range(0, 9))
            0:       return ($urandom_range(0, 1) == 1) ? 16'sh7FFF : 16'sh8000;
            1, 2:    return t_value'($urandom);
            3, 4, 5: return t_value'(int'($urandom_range(0, 1024)) - 512);
            default: return t_value'(int'($urandom_range(0, 128)) - 64);
        endcase
    endfunction

    // Offers one input transaction, starting at a falling edge, and returns at
    // the falling edge after it was accepted. Valid stays high from one
    // transaction to the next within a burst. Between bursts it drops for a
    // random gap when gaps are enabled.
    task automatic send_item(input t_op op, input t_index idx, input t_value val);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = sender_gaps ? $urandom_range(0, 8) : 0;
            if (gap != 0) begin
                sample_if.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        sample_if.valid <= 1'b1;
        sample_if.op    <= op;
        sample_if.index <= idx;
        sample_if.value <= val;
        @(posedge i_clk);
        while (!sample_if.ready)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic stop_sending();
        sample_if.valid <= 1'b0;
        burst_left = 0;
    endtask

    // Waits until every expected result has arrived, then lets the block
    // finish whatever work a frame without results may still hold.
    task automatic settle_idle();
        while (layer_chk.pending_count() != 0)
            @(negedge i_clk);
        repeat (layer_chk.busy_cycles() + 8) @(negedge i_clk);
    endtask

    // Writes the three registers back to back, optionally preceded by a
    // write to the unused index. Valid stays high between the writes.
    task automatic program_layer(input t_cfg_data c_raw, input t_cfg_data o_raw,
                                 input t_cfg_data k_raw, input bit poke_spare);
        t_cfg_index idx_list [$];
        t_cfg_data  data_list [$];
        if (poke_spare) begin
            idx_list.push_back(REG_SPARE);
            data_list.push_back(5'h1F);
        end
        idx_list.push_back(REG_IN_CHANNELS);
        data_list.push_back(c_raw);
        idx_list.push_back(REG_OUT_CHANNELS);
        data_list.push_back(o_raw);
        idx_list.push_back(REG_WINDOW_LEN);
        data_list.push_back(k_raw);
        foreach (idx_list[i]) begin
            cfg_if.valid <= 1'b1;
            cfg_if.index <= idx_list[i];
            cfg_if.data  <= data_list[i];
            @(posedge i_clk);
            while (!cfg_if.ready)
                @(posedge i_clk);
            @(negedge i_clk);
        end
        cfg_if.valid <= 1'b0;
    endtask

    // One layer setting: program it, then stream random transactions. Most
    // are samples so the window fills and frames complete. Weight writes
    // mostly land inside the addresses the current shape uses, bias writes
    // sometimes go past the bias store, and restarts are rare enough that
    // even the largest window fills several times.
    task automatic run_phase(input t_cfg_data c_raw, input t_cfg_data o_raw,
                             input t_cfg_data k_raw, input bit poke_spare,
                             input bit with_gaps, input int unsigned hold_len);
        int unsigned budget;
        int unsigned done;
        int unsigned span;
        int unsigned restart_pm;
        int unsigned roll;
        int unsigned idx;
        program_layer(c_raw, o_raw, k_raw, poke_spare);
        sender_gaps = with_gaps;
        if (hold_len != 0)
            hold_request = hold_len;
        span       = layer_chk.eff_in() * layer_chk.eff_win() * layer_chk.eff_out();
        budget     = layer_chk.eff_in() * (layer_chk.eff_win() + 3) + 16;
        restart_pm = 1000 / (4 * layer_chk.eff_in() * layer_chk.eff_win() + 20);
        if (budget < 40)
            budget = 40;
        if (restart_pm < 1)
            restart_pm = 1;
        done = 0;
        while (done < budget) begin
            roll = $urandom_range(0, 999);
            if (roll < restart_pm) begin
                send_item(OP_RESTART, t_index'($urandom), pick_value());
                done++;
            end else if (roll < 800) begin
                send_item(OP_SAMPLE, t_index'($urandom), pick_value());
                done++;
            end else if (roll < 900) begin
                idx = ($urandom_range(0, 3) != 0) ? $urandom_range(0, span - 1)
                                                  : $urandom_range(0, WEIGHT_DEPTH - 1);
                send_item(OP_WEIGHT, t_index'(idx), pick_value());
                done++;
            end else begin
                // Writes past the bias store are ignored and do not count.
                idx = ($urandom_range(0, 3) != 0) ? $urandom_range(0, BIAS_DEPTH - 1)
                                                  : $urandom_range(BIAS_DEPTH, 2047);
                send_item(OP_BIAS, t_index'(idx), pick_value());
                if (idx < BIAS_DEPTH)
                    done++;
            end
        end
        stop_sending();
        settle_idle();
        phases_run++;
    endtask

    initial begin
        layer_chk      = new();
        burst_left     = 0;
        sender_gaps    = 1'b1;
        hold_request   = 0;
        phases_run     = 0;
        stalled_cycles = 0;
        sample_if.valid = 1'b0;
        sample_if.op    = OP_WEIGHT;
        sample_if.index = '0;
        sample_if.value = '0;
        cfg_if.valid    = 1'b0;
        cfg_if.index    = REG_IN_CHANNELS;
        cfg_if.data     = '0;
        i_rst_n         = 1'b0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed checks at the reset shape of one channel, one filter and a
        // window of one frame, so each sample gives exactly one result from
        // bias 0 and weight 0. They cover saturation from both sign
        // combinations, a negative sum clipped to zero, a negative bias, the
        // truncation of a small positive sum, ignored bias writes past the
        // store, the top weight address and a restart.
        send_item(OP_BIAS, 11'd0, 16'sh7FFF);
        send_item(OP_WEIGHT, 11'd0, 16'sh7FFF);
        send_item(OP_SAMPLE, 11'd0, 16'sh7FFF);
        send_item(OP_WEIGHT, 11'd0, 16'sh8000);
        send_item(OP_SAMPLE, 11'd0, 16'sh8000);
        send_item(OP_SAMPLE, 11'd0, 16'sh7FFF);
        send_item(OP_BIAS, 11'd0, 16'sh8000);
        send_item(OP_WEIGHT, 11'd0, 16'sh0001);
        send_item(OP_SAMPLE, 11'd0, 16'sh0000);
        send_item(OP_BIAS, 11'd0, 16'sh0001);
        send_item(OP_SAMPLE, 11'd2047, 16'sh0000);
        send_item(OP_BIAS, 11'd16, 16'sh5A5A);
        send_item(OP_BIAS, 11'd2047, 16'shFFFF);
        send_item(OP_SAMPLE, 11'd0, 16'sh00FF);
        send_item(OP_BIAS, 11'd0, 16'sh0000);
        send_item(OP_SAMPLE, 11'd0, 16'sh00FF);
        send_item(OP_SAMPLE, 11'd0, 16'sh0100);
        send_item(OP_WEIGHT, 11'd2047, 16'shFFFF);
        send_item(OP_RESTART, 11'd2047, 16'shFFFF);
        send_item(OP_SAMPLE, 11'd0, 16'shFFFF);
        send_item(OP_SAMPLE, 11'd0, 16'sh4000);

        // Every bias and every weight that a later shape reads gets a value
        // before any shape larger than the reset one can read it.
        for (int i = 0; i < WEIGHT_PRELOAD; i++)
            send_item(OP_WEIGHT, t_index'(i), pick_value());
        for (int i = 0; i < BIAS_DEPTH; i++)
            send_item(OP_BIAS, t_index'(i), pick_value());
        stop_sending();
        settle_idle();

        // Layer shapes, given as raw register values. Out-of-range values
        // (zero, above the maximum, and a window value whose upper bit is
        // dropped) are among them, and each count reaches its maximum in
        // some shape. The shape with sixteen filters and a one-frame window
        // also carries the long output hold-off while the sender keeps
        // offering samples.
        run_phase(5'd3,  5'd4,  5'd2,  1'b0, 1'b1, 0);
        run_phase(5'd1,  5'd16, 5'd8,  1'b1, 1'b1, 0);
        run_phase(5'd0,  5'd0,  5'd0,  1'b0, 1'b0, 0);
        run_phase(5'd2,  5'd31, 5'd17, 1'b0, 1'b0, 3000);
        run_phase(5'd31, 5'd1,  5'd2,  1'b1, 1'b1, 0);
        run_phase(5'd3,  5'd5,  5'd15, 1'b0, 1'b1, 0);
        run_phase(5'd2,  5'd3,  5'd4,  1'b0, 1'b0, 0);

        if (layer_chk.pending_count() != 0)
            $display("%0t: %0d expected results never arrived", $time,
                     layer_chk.pending_count());
        $display("Covered %0d input transactions and %0d results over %0d layer shapes,",
                 layer_chk.items_taken, layer_chk.outputs_checked, phases_run);
        $display("with out-of-range registers, restarts and a long output hold-off.");
        if (layer_chk.errors == 0 && layer_chk.pending_count() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/c1r_pkg.sv
hw/rtl/c1r_ifs.sv
hw/rtl/c1r_mac.sv
hw/rtl/conv1d_relu_stream.sv
tb/tb_conv1d_relu_stream.sv
